/* rtl/swc_pkg.sv */
// Shared types, constants and the chaser pattern table for the stopwatch block.
`timescale 1ns / 1ps

package swc_pkg;

   // Field widths
   localparam int unsigned BTN_W   = 5;
   localparam int unsigned MS_W    = 10;
   localparam int unsigned SEC_W   = 6;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned HOUR_W  = 10;
   localparam int unsigned DLY_W   = 12;
   localparam int unsigned STEP_W  = 10;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned LED_W   = 8;
   localparam int unsigned CSR_A_W = 2;
   localparam int unsigned CSR_D_W = 12;
   localparam int unsigned REQ_W   = 8;
   localparam int unsigned RSP_W   = 48;

   // Rollover limits
   localparam logic [MS_W-1:0]   MS_WRAP   = 10'd1000;
   localparam logic [SEC_W-1:0]  SEC_WRAP  = 6'd60;
   localparam logic [MIN_W-1:0]  MIN_WRAP  = 6'd60;
   localparam logic [HOUR_W-1:0] HOUR_WRAP = 10'd1000;

   // Register reset values
   localparam logic [DLY_W-1:0]  DELAY_MIN_RST  = 12'd500;
   localparam logic [DLY_W-1:0]  DELAY_MAX_RST  = 12'd2000;
   localparam logic [STEP_W-1:0] DELAY_STEP_RST = 10'd300;
   localparam logic [DLY_W-1:0]  DELAY_SAT      = 12'd4095;

   // Chaser index limits
   localparam logic [IDX_W-1:0] IDX_FIRST = 3'd0;
   localparam logic [IDX_W-1:0] IDX_LAST  = 3'd4;

   // Button bit positions
   localparam int unsigned BTN_START  = 0;
   localparam int unsigned BTN_STOP   = 1;
   localparam int unsigned BTN_CLEAR  = 2;
   localparam int unsigned BTN_SLOWER = 3;
   localparam int unsigned BTN_FASTER = 4;

   // Configuration register indexes
   typedef enum logic [CSR_A_W-1:0] {
      CSR_DELAY_MIN  = 2'd0,
      CSR_DELAY_MAX  = 2'd1,
      CSR_DELAY_STEP = 2'd2
   } csr_index_type;

   // Symmetric chaser patterns; indexes past the table show all LEDs off
   function automatic logic [LED_W-1:0] chase_pattern(input logic [IDX_W-1:0] idx);
      logic [LED_W-1:0] pat;
      case (idx)
         3'd0:    pat = 8'b1111_1111;
         3'd1:    pat = 8'b0111_1110;
         3'd2:    pat = 8'b0011_1100;
         3'd3:    pat = 8'b0001_1000;
         default: pat = 8'b0000_0000;
      endcase
      return pat;
   endfunction

endpackage

/* rtl/stopwatch_and_led_chaser_top.sv */
// Stopwatch with bouncing LED chaser: button handling, time counting and result stage.
`timescale 1ns / 1ps

//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  req     | in  | req_tvalid/tready    | req_tdata: buttons[4:0], tick[5], zeros
//  rsp     | out | rsp_tvalid/tready    | rsp_tdata: hours, minutes, seconds,
//          |     |                      |            millis, leds, running, zeros
//  csr     | in  | csr_we               | csr_addr (register index), csr_wdata
//
// One transfer in gives one transfer out. All state updates for an item happen in
// the cycle it is accepted; the result is loaded into the output register at the same time.
// Sustained rate is one item per cycle while rsp_tready stays high, as there is a single output register.
// req_tready is high while the output register is empty or being drained this cycle,
// and held low during reset so no transfer is taken and then dropped.
// Reset (synchronous, active high) restores the counters, the chaser and the
// delay registers to their power-up values, with no clearing pass.

module stopwatch_and_led_chaser_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [4:0] buttons, [5] tick, [7:6] zero
   input  logic [swc_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [9:0] hours, [15:10] minutes, [21:16] seconds, [31:22] millis,
   // [39:32] leds, [40] running, [47:41] zero
   output logic [swc_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_we,
   input  logic [swc_pkg::CSR_A_W-1:0]   csr_addr,
   input  logic [swc_pkg::CSR_D_W-1:0]   csr_wdata
);

   // Configuration registers
   logic [swc_pkg::DLY_W-1:0]  delay_min_ff,  delay_min_in;
   logic [swc_pkg::DLY_W-1:0]  delay_max_ff,  delay_max_in;
   logic [swc_pkg::STEP_W-1:0] delay_step_ff, delay_step_in;

   // Block state
   logic [swc_pkg::BTN_W-1:0]  last_btn_ff,    last_btn_in;
   logic                       run_ff,         run_in;
   logic [swc_pkg::MS_W-1:0]   ms_ff,          ms_in;
   logic [swc_pkg::SEC_W-1:0]  sec_ff,         sec_in;
   logic [swc_pkg::MIN_W-1:0]  min_ff,         min_in;
   logic [swc_pkg::HOUR_W-1:0] hour_ff,        hour_in;
   logic [swc_pkg::DLY_W-1:0]  chase_ticks_ff, chase_ticks_in;
   logic [swc_pkg::IDX_W-1:0]  chase_idx_ff,   chase_idx_in;
   logic                       chase_up_ff,    chase_up_in;
   logic [swc_pkg::DLY_W-1:0]  chase_dly_ff,   chase_dly_in;
   logic [swc_pkg::LED_W-1:0]  led_ff,         led_in;

   // Output stage
   logic                       rsp_valid_ff,   rsp_valid_in;
   logic [swc_pkg::RSP_W-1:0]  rsp_data_ff,    rsp_data_in;

   logic                       req_fire;
   logic [swc_pkg::BTN_W-1:0]  btn;
   logic                       tick;
   logic [swc_pkg::BTN_W-1:0]  fresh;

   assign btn        = req_tdata[swc_pkg::BTN_W-1:0];
   assign tick       = req_tdata[swc_pkg::BTN_W];
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign fresh      = btn & ~last_btn_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration writes; an index past the list is dropped
   always_comb begin
      delay_min_in  = delay_min_ff;
      delay_max_in  = delay_max_ff;
      delay_step_in = delay_step_ff;
      if (csr_we) begin
         unique case (swc_pkg::csr_index_type'(csr_addr))
            swc_pkg::CSR_DELAY_MIN:  delay_min_in  = csr_wdata;
            swc_pkg::CSR_DELAY_MAX:  delay_max_in  = csr_wdata;
            swc_pkg::CSR_DELAY_STEP: delay_step_in = csr_wdata[swc_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Per-item update: button action, then time counting, then the chaser
   always_comb begin
      logic [swc_pkg::DLY_W:0]    dly_sum;
      logic [swc_pkg::DLY_W-1:0]  step_ext;
      logic [swc_pkg::MS_W-1:0]   ms_inc;
      logic [swc_pkg::SEC_W-1:0]  sec_inc;
      logic [swc_pkg::MIN_W-1:0]  min_inc;
      logic [swc_pkg::HOUR_W-1:0] hour_inc;

      last_btn_in    = last_btn_ff;
      run_in         = run_ff;
      ms_in          = ms_ff;
      sec_in         = sec_ff;
      min_in         = min_ff;
      hour_in        = hour_ff;
      chase_ticks_in = chase_ticks_ff;
      chase_idx_in   = chase_idx_ff;
      chase_up_in    = chase_up_ff;
      chase_dly_in   = chase_dly_ff;
      led_in         = led_ff;

      step_ext = {{(swc_pkg::DLY_W-swc_pkg::STEP_W){1'b0}}, delay_step_ff};
      dly_sum  = {1'b0, chase_dly_ff} + {1'b0, step_ext};
      ms_inc   = '0;
      sec_inc  = '0;
      min_inc  = '0;
      hour_inc = '0;

      if (req_fire) begin
         last_btn_in = btn;

         // Lowest newly pressed button wins
         if (fresh[swc_pkg::BTN_START]) begin
            run_in = 1'b1;
         end else if (fresh[swc_pkg::BTN_STOP]) begin
            run_in = 1'b0;
         end else if (fresh[swc_pkg::BTN_CLEAR]) begin
            ms_in   = '0;
            sec_in  = '0;
            min_in  = '0;
            hour_in = '0;
         end else if (fresh[swc_pkg::BTN_SLOWER]) begin
            if (chase_dly_ff < delay_max_ff) begin
               chase_dly_in = dly_sum[swc_pkg::DLY_W] ? swc_pkg::DELAY_SAT
                                                       : dly_sum[swc_pkg::DLY_W-1:0];
            end
         end else if (fresh[swc_pkg::BTN_FASTER]) begin
            if (chase_dly_ff > delay_min_ff) begin
               chase_dly_in = (chase_dly_ff > step_ext) ? chase_dly_ff - step_ext : '0;
            end
         end

         if (tick) begin
            if (run_in) begin
               ms_inc = ms_in + 1'b1;
               if (ms_inc >= swc_pkg::MS_WRAP) begin
                  ms_in   = '0;
                  sec_inc = sec_in + 1'b1;
                  if (sec_inc >= swc_pkg::SEC_WRAP) begin
                     sec_in  = '0;
                     min_inc = min_in + 1'b1;
                     if (min_inc >= swc_pkg::MIN_WRAP) begin
                        min_in   = '0;
                        hour_inc = hour_in + 1'b1;
                        hour_in  = (hour_inc >= swc_pkg::HOUR_WRAP) ? '0 : hour_inc;
                     end else begin
                        min_in = min_inc;
                     end
                  end else begin
                     sec_in = sec_inc;
                  end
               end else begin
                  ms_in = ms_inc;
               end
            end
            if (chase_ticks_ff != swc_pkg::DELAY_SAT) begin
               chase_ticks_in = chase_ticks_ff + 1'b1;
            end
         end

         // Show the next pattern once the count passes the delay; bounce at the ends
         if (chase_ticks_in > chase_dly_in) begin
            chase_ticks_in = '0;
            led_in         = swc_pkg::chase_pattern(chase_idx_ff);
            if (chase_idx_ff >= swc_pkg::IDX_LAST) begin
               chase_up_in = 1'b0;
            end
            if (chase_idx_ff == swc_pkg::IDX_FIRST) begin
               chase_up_in = 1'b1;
            end
            chase_idx_in = chase_up_in ? chase_idx_ff + 1'b1 : chase_idx_ff - 1'b1;
         end
      end
   end

   // Result register: load on accept, clear when drained with nothing behind it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, run_in, led_in, ms_in, sec_in, min_in, hour_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_min_ff   <= swc_pkg::DELAY_MIN_RST;
         delay_max_ff   <= swc_pkg::DELAY_MAX_RST;
         delay_step_ff  <= swc_pkg::DELAY_STEP_RST;
         last_btn_ff    <= '0;
         run_ff         <= 1'b1;
         ms_ff          <= '0;
         sec_ff         <= '0;
         min_ff         <= '0;
         hour_ff        <= '0;
         chase_ticks_ff <= '0;
         chase_idx_ff   <= '0;
         chase_up_ff    <= 1'b1;
         chase_dly_ff   <= swc_pkg::DELAY_MIN_RST;
         led_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         delay_min_ff   <= delay_min_in;
         delay_max_ff   <= delay_max_in;
         delay_step_ff  <= delay_step_in;
         last_btn_ff    <= last_btn_in;
         run_ff         <= run_in;
         ms_ff          <= ms_in;
         sec_ff         <= sec_in;
         min_ff         <= min_in;
         hour_ff        <= hour_in;
         chase_ticks_ff <= chase_ticks_in;
         chase_idx_ff   <= chase_idx_in;
         chase_up_ff    <= chase_up_in;
         chase_dly_ff   <= chase_dly_in;
         led_ff         <= led_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Time fields stay within their ranges
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      ms_ff < swc_pkg::MS_WRAP && sec_ff < swc_pkg::SEC_WRAP &&
      min_ff < swc_pkg::MIN_WRAP && hour_ff < swc_pkg::HOUR_WRAP)
      else $error("time counter out of range");

   // Every accepted item leaves a result in the output register
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   // State moves only with an accepted item
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(ms_ff) && $stable(chase_ticks_ff) && $stable(chase_dly_ff)
                    && $stable(run_ff))
      else $error("state changed without an accepted item");

   // The chase count never stays above the delay after an item
   a_chase_bound: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> chase_ticks_ff <= chase_dly_ff)
      else $error("chase count left above delay");

endmodule

/* sim/stopwatch_and_led_chaser_top_tb.sv */
// Self-checking testbench for the stopwatch and LED chaser block, with a per-item predictor.
`timescale 1ns / 1ps

module stopwatch_and_led_chaser_top_tb;

   // One result transfer, split into its fields
   typedef struct packed {
      logic [swc_pkg::HOUR_W-1:0] hours;
      logic [swc_pkg::MIN_W-1:0]  minutes;
      logic [swc_pkg::SEC_W-1:0]  seconds;
      logic [swc_pkg::MS_W-1:0]   millis;
      logic [swc_pkg::LED_W-1:0]  leds;
      logic                       running;
   } status_type;

   // Rough number of input transfers for the whole run
   localparam int ITEM_TARGET = 1100;

   // DUT ports; every input holds a known value from time zero
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [swc_pkg::REQ_W-1:0]     req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [swc_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          csr_we = 1'b0;
   logic [swc_pkg::CSR_A_W-1:0]   csr_addr = '0;
   logic [swc_pkg::CSR_D_W-1:0]   csr_wdata = '0;

   // Predictor copy of the registers and the block state
   logic [swc_pkg::DLY_W-1:0]  cfg_delay_min;
   logic [swc_pkg::DLY_W-1:0]  cfg_delay_max;
   logic [swc_pkg::STEP_W-1:0] cfg_delay_step;
   logic [swc_pkg::BTN_W-1:0]  prev_buttons;
   logic                       run_state;
   logic [swc_pkg::MS_W-1:0]   ms_cnt;
   logic [swc_pkg::SEC_W-1:0]  sec_cnt;
   logic [swc_pkg::MIN_W-1:0]  min_cnt;
   logic [swc_pkg::HOUR_W-1:0] hour_cnt;
   logic [swc_pkg::DLY_W-1:0]  chase_ticks;
   logic [swc_pkg::IDX_W-1:0]  chase_idx;
   logic                       chase_rising;
   logic [swc_pkg::DLY_W-1:0]  chase_delay;
   logic [swc_pkg::LED_W-1:0]  led_state;
   logic [swc_pkg::LED_W-1:0]  chase_leds [0:4] = '{8'hFF, 8'h7E, 8'h3C, 8'h18, 8'h00};

   // Statuses predicted for accepted input transfers, oldest first
   status_type expected_status [$];

   // Traffic shaping: no_idle turns off random gaps on both sides,
   // stall_request asks the receiver for one long hold-off
   bit no_idle = 1'b0;
   bit stall_request = 1'b0;
   int hold_left = 0;

   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int csr_writes = 0;

   stopwatch_and_led_chaser_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #20_000_000;
      $display("stopwatch_and_led_chaser_top: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   task automatic reset_predictor();
      cfg_delay_min  = swc_pkg::DELAY_MIN_RST;
      cfg_delay_max  = swc_pkg::DELAY_MAX_RST;
      cfg_delay_step = swc_pkg::DELAY_STEP_RST;
      prev_buttons   = '0;
      run_state      = 1'b1;
      ms_cnt         = '0;
      sec_cnt        = '0;
      min_cnt        = '0;
      hour_cnt       = '0;
      chase_ticks    = '0;
      chase_idx      = swc_pkg::IDX_FIRST;
      chase_rising   = 1'b1;
      chase_delay    = swc_pkg::DELAY_MIN_RST;
      led_state      = '0;
   endtask

   // Advance the predicted state by one input item and return the status it shows.
   // Order inside one item: button action, time counting, then the chaser check.
   task automatic advance_stopwatch(input logic [swc_pkg::BTN_W-1:0] btn, input logic tk,
                                    output status_type st);
      logic [swc_pkg::BTN_W-1:0] fresh;
      logic [swc_pkg::DLY_W:0]   sum;
      logic [swc_pkg::DLY_W-1:0] step_ext;
      fresh = btn & ~prev_buttons;
      prev_buttons = btn;
      step_ext = {{(swc_pkg::DLY_W-swc_pkg::STEP_W){1'b0}}, cfg_delay_step};

      // Lowest newly pressed button wins
      if (fresh[swc_pkg::BTN_START]) begin
         run_state = 1'b1;
      end else if (fresh[swc_pkg::BTN_STOP]) begin
         run_state = 1'b0;
      end else if (fresh[swc_pkg::BTN_CLEAR]) begin
         ms_cnt   = '0;
         sec_cnt  = '0;
         min_cnt  = '0;
         hour_cnt = '0;
      end else if (fresh[swc_pkg::BTN_SLOWER]) begin
         // Test only before the step, so the delay may overshoot the maximum
         if (chase_delay < cfg_delay_max) begin
            sum = {1'b0, chase_delay} + {1'b0, step_ext};
            chase_delay = sum[swc_pkg::DLY_W] ? swc_pkg::DELAY_SAT : sum[swc_pkg::DLY_W-1:0];
         end
      end else if (fresh[swc_pkg::BTN_FASTER]) begin
         if (chase_delay > cfg_delay_min) begin
            chase_delay = (chase_delay > step_ext) ? chase_delay - step_ext : '0;
         end
      end

      if (tk) begin
         if (run_state) begin
            ms_cnt = ms_cnt + 1'b1;
            if (ms_cnt >= swc_pkg::MS_WRAP) begin
               ms_cnt  = '0;
               sec_cnt = sec_cnt + 1'b1;
               if (sec_cnt >= swc_pkg::SEC_WRAP) begin
                  sec_cnt = '0;
                  min_cnt = min_cnt + 1'b1;
                  if (min_cnt >= swc_pkg::MIN_WRAP) begin
                     min_cnt  = '0;
                     hour_cnt = hour_cnt + 1'b1;
                     if (hour_cnt >= swc_pkg::HOUR_WRAP) hour_cnt = '0;
                  end
               end
            end
         end
         // Chase count saturates, so a delay at the top never fires
         if (chase_ticks < swc_pkg::DELAY_SAT) chase_ticks = chase_ticks + 1'b1;
      end

      // Show the next pattern and bounce at both ends of the table
      if (chase_ticks > chase_delay) begin
         chase_ticks = '0;
         led_state = (chase_idx <= swc_pkg::IDX_LAST) ? chase_leds[chase_idx] : '0;
         if (chase_idx >= swc_pkg::IDX_LAST) chase_rising = 1'b0;
         if (chase_idx == swc_pkg::IDX_FIRST) chase_rising = 1'b1;
         chase_idx = chase_rising ? chase_idx + 1'b1 : chase_idx - 1'b1;
      end

      st.hours   = hour_cnt;
      st.minutes = min_cnt;
      st.seconds = sec_cnt;
      st.millis  = ms_cnt;
      st.leds    = led_state;
      st.running = run_state;
   endtask

   // Offer one item, wait for its transfer, then queue the predicted status.
   // Valid is left high after the transfer so the next call can keep it high.
   task automatic send_item(input logic [swc_pkg::BTN_W-1:0] btn, input logic tk);
      status_type st;
      while (!no_idle && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, tk, btn};
      do @(posedge clock); while (!req_tready);
      advance_stopwatch(btn, tk, st);
      expected_status.push_back(st);
      items_sent++;
   endtask

   // Press a button for one item and release it on the next
   task automatic press(input logic [swc_pkg::BTN_W-1:0] btn, input logic tk);
      send_item(btn, tk);
      send_item('0, tk);
   endtask

   task automatic send_random_item();
      logic [swc_pkg::BTN_W-1:0] btn;
      int r;
      r = $urandom_range(0, 99);
      // Mostly quiet or single presses so that edges and runs of ticks occur
      if (r < 45)      btn = '0;
      else if (r < 80) btn = 5'b00001 << $urandom_range(0, 4);
      else             btn = 5'($urandom_range(0, 31));
      send_item(btn, $urandom_range(0, 99) < 85);
   endtask

   // Drop valid, wait until every expected status has arrived, then settle
   task automatic wait_results(input int settle);
      int guard;
      req_tvalid <= 1'b0;
      guard = 0;
      while (expected_status.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_status.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_status.size()));
         expected_status.delete();
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input swc_pkg::csr_index_type idx,
                            input logic [swc_pkg::CSR_D_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_writes++;
   endtask

   // Write all three registers while the block is idle
   task automatic configure(input logic [swc_pkg::DLY_W-1:0] dmin,
                            input logic [swc_pkg::DLY_W-1:0] dmax,
                            input logic [swc_pkg::STEP_W-1:0] dstep);
      wait_results(3);
      write_reg(swc_pkg::CSR_DELAY_MIN, dmin);
      write_reg(swc_pkg::CSR_DELAY_MAX, dmax);
      write_reg(swc_pkg::CSR_DELAY_STEP, {2'b00, dstep});
      csr_we <= 1'b0;
      cfg_delay_min  = dmin;
      cfg_delay_max  = dmax;
      cfg_delay_step = dstep;
   endtask

   // Start, stop, clear and faster alone, held buttons, stacked presses and ticks on and off
   task automatic test_directed();
      send_item(5'b00000, 1'b0);
      send_item(5'b00000, 1'b1);
      send_item(5'b00001, 1'b1);            // start while already running
      send_item(5'b00000, 1'b1);
      send_item(5'b00010, 1'b1);            // stop
      send_item(5'b00000, 1'b1);            // ticks while stopped
      send_item(5'b00000, 1'b1);
      send_item(5'b00001, 1'b1);            // start again
      send_item(5'b00001, 1'b1);            // held, not a new press
      send_item(5'b00100, 1'b1);            // clear
      send_item(5'b00000, 1'b0);
      send_item(5'b11111, 1'b1);            // all at once, start wins
      send_item(5'b11111, 1'b1);            // all held
      send_item(5'b00000, 1'b0);
      send_item(5'b11110, 1'b0);            // stop wins over the rest
      send_item(5'b00000, 1'b1);
      send_item(5'b11100, 1'b1);            // clear wins
      send_item(5'b00000, 1'b1);
      send_item(5'b11000, 1'b1);            // slower wins over faster
      send_item(5'b00000, 1'b1);
      send_item(5'b10000, 1'b1);            // faster
      send_item(5'b00000, 1'b1);
      send_item(5'b00001, 1'b0);            // restart
      send_item(5'b00000, 1'b1);
   endtask

   // Saturation at the top, floor at zero, overshoot past the limits, blocked steps
   task automatic test_delay_limits();
      configure(12'd0, 12'd4095, 10'd1023);
      repeat (6) press(5'b01000, 1'b1);     // climb to 4095 and stay there
      repeat (6) press(5'b10000, 1'b1);     // drop to zero and stay there
      configure(12'd4095, 12'd0, 10'd1);
      press(5'b01000, 1'b1);                // both directions blocked
      press(5'b10000, 1'b1);
      configure(12'd100, 12'd200, 10'd150);
      repeat (3) press(5'b01000, 1'b1);     // 0, 150, 300: passes the maximum
      repeat (3) press(5'b10000, 1'b1);     // 150, 0: passes the minimum
   endtask

   // Short delays so the chaser bounces through the table many times
   task automatic test_chaser();
      configure(12'd0, 12'd4095, 10'd1);
      repeat (100) send_item('0, $urandom_range(0, 99) < 90);
      press(5'b01000, 1'b1);
      repeat (30) send_item('0, 1'b1);
      press(5'b01000, 1'b1);
      repeat (30) send_item('0, 1'b1);
   endtask

   // Long receiver hold-off fills the block; then the sender pauses for a full drain
   task automatic test_backpressure();
      stall_request = 1'b1;
      repeat (40) send_random_item();
      wait_results(0);
      repeat (20) send_random_item();
   endtask

   // Enough running ticks to carry milliseconds over into the seconds count;
   // the first half goes back to back with no idling on either side
   task automatic test_rollover();
      int n;
      press(5'b00001, 1'b1);
      n = int'(swc_pkg::MS_WRAP) - int'(ms_cnt) + 8;
      no_idle = 1'b1;
      repeat (n / 2) send_item('0, 1'b1);
      no_idle = 1'b0;
      repeat (n - n / 2) send_item('0, 1'b1);
   endtask

   // Random sequences under several register settings, extremes included
   task automatic test_random();
      int per_setting;
      per_setting = (ITEM_TARGET - items_sent) / 5;
      if (per_setting < 20) per_setting = 20;
      configure(swc_pkg::DELAY_MIN_RST, swc_pkg::DELAY_MAX_RST, swc_pkg::DELAY_STEP_RST);
      repeat (per_setting) send_random_item();
      configure(12'd0, 12'd4095, 10'd1023);
      repeat (per_setting) send_random_item();
      configure(12'd0, 12'd60, 10'd13);
      repeat (per_setting) send_random_item();
      configure(12'd4095, 12'd0, 10'd1);
      repeat (per_setting) send_random_item();
      configure(12'($urandom_range(0, 50)), 12'($urandom_range(0, 4095)),
                10'($urandom_range(1, 1023)));
      repeat (per_setting) send_random_item();
   endtask

   // Receiver: random ready, or held low for the requested stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left = 200;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(0, 99) >= 21);
         end
      end
   end

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   results_seen, name, got, want));
   endtask

   // Compare each result transfer against the oldest prediction
   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_status.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      results_seen));
         end else begin
            want = expected_status.pop_front();
            check_field("hours",   rsp_tdata[9:0],   want.hours);
            check_field("minutes", rsp_tdata[15:10], want.minutes);
            check_field("seconds", rsp_tdata[21:16], want.seconds);
            check_field("millis",  rsp_tdata[31:22], want.millis);
            check_field("leds",    rsp_tdata[39:32], want.leds);
            check_field("running", rsp_tdata[40],    want.running);
            check_field("padding", rsp_tdata[47:41], 0);
         end
         results_seen++;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      reset_predictor();

      test_directed();
      test_delay_limits();
      test_chaser();
      test_backpressure();
      test_rollover();
      test_random();
      wait_results(4);

      $display("Covered %0d items and %0d results: button priority, delay limits,",
               items_sent, results_seen);
      $display("chaser bounce, seconds rollover, back-pressure; %0d register writes.",
               csr_writes);
      if (errors == 0) begin
         $display("stopwatch_and_led_chaser_top: match");
      end else begin
         $display("stopwatch_and_led_chaser_top: mismatch");
      end
      $finish;
   end

endmodule
